// File: rtl/core/aat_pkg.sv
// Shared types and constants for the axis-aligned box affine transform block.
package aat_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned CFG_W   = 64;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned Q_FRAC  = 16;

    // Product of two Q16.16 values, the sum of three of them, and the
    // floored sum plus translation, all held as signed words.
    localparam int unsigned PROD_W = 2 * COORD_W;
    localparam int unsigned SUM_W  = PROD_W + 2;
    localparam int unsigned ACC_W  = SUM_W - Q_FRAC + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW0_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW0_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2_A = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2_B = 3'd5;

    // Reset matrix is the identity.
    localparam logic [CFG_W-1:0] ROW0_A_RESET = 64'h0001_0000_0000_0000;
    localparam logic [CFG_W-1:0] ROW0_B_RESET = 64'h0000_0000_0000_0000;
    localparam logic [CFG_W-1:0] ROW1_A_RESET = 64'h0000_0000_0001_0000;
    localparam logic [CFG_W-1:0] ROW1_B_RESET = 64'h0000_0000_0000_0000;
    localparam logic [CFG_W-1:0] ROW2_A_RESET = 64'h0000_0000_0000_0000;
    localparam logic [CFG_W-1:0] ROW2_B_RESET = 64'h0001_0000_0000_0000;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sd2147483648);

    // Per-stage load enables handed from the pipeline control to each axis.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } aat_load_t;

endpackage

// File: rtl/core/aabb_affine_transform.sv
// Top level of the axis-aligned box affine transform pipeline.
//
//   Channel  Handshake              Payload
//   -------  ---------------------  ----------------------------------------------
//   in       in_valid / in_ready    lo_x lo_y lo_z hi_x hi_y hi_z (Q16.16)
//   out      out_valid / out_ready  out_lo_x..out_hi_z (Q16.16), clipped
//   cfg      cfg_write              cfg_index, cfg_data (matrix rows)
//
// A box's result passes the four register stages (multiply, term extremes,
// sum, floor and clamp) before it is valid on the output, and one box is
// accepted per cycle unless back-pressure from a stalled output reaches the
// first stage. Reset clears the stage valid bits and loads the identity
// matrix. A stalled output holds its transaction and back-pressure moves up
// only as far as the first empty stage, so bubbles are squeezed out and
// nothing is dropped or repeated.
//
// Each output coordinate is a sum of three terms, each depending on a single
// input axis, so the smallest and largest of the eight transformed corners
// come from the per-term smaller and larger product. Floor and clamping are
// monotonic, so they are applied only to those two sums. A corner clamps
// exactly when the largest sum is above range or the smallest is below it.
module aabb_affine_transform
    import aat_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,

    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [COORD_W-1:0]  lo_x,
    input  logic signed [COORD_W-1:0]  lo_y,
    input  logic signed [COORD_W-1:0]  lo_z,
    input  logic signed [COORD_W-1:0]  hi_x,
    input  logic signed [COORD_W-1:0]  hi_y,
    input  logic signed [COORD_W-1:0]  hi_z,

    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [COORD_W-1:0]  out_lo_x,
    output logic signed [COORD_W-1:0]  out_lo_y,
    output logic signed [COORD_W-1:0]  out_lo_z,
    output logic signed [COORD_W-1:0]  out_hi_x,
    output logic signed [COORD_W-1:0]  out_hi_y,
    output logic signed [COORD_W-1:0]  out_hi_z,
    output logic                       clipped
);

    // Matrix registers, one pair per output row.
    logic [CFG_W-1:0] row0_a_reg, row0_b_reg;
    logic [CFG_W-1:0] row1_a_reg, row1_b_reg;
    logic [CFG_W-1:0] row2_a_reg, row2_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_a_reg <= ROW0_A_RESET;
            row0_b_reg <= ROW0_B_RESET;
            row1_a_reg <= ROW1_A_RESET;
            row1_b_reg <= ROW1_B_RESET;
            row2_a_reg <= ROW2_A_RESET;
            row2_b_reg <= ROW2_B_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ROW0_A: row0_a_reg <= cfg_data;
                CFG_ROW0_B: row0_b_reg <= cfg_data;
                CFG_ROW1_A: row1_a_reg <= cfg_data;
                CFG_ROW1_B: row1_b_reg <= cfg_data;
                CFG_ROW2_A: row2_a_reg <= cfg_data;
                CFG_ROW2_B: row2_b_reg <= cfg_data;
                default: ;  // Indexes past the last register are ignored.
            endcase
        end
    end

    // Pipeline control. A stage can take new data when it is empty or when
    // its own contents move on in the same cycle.
    logic      v1_reg, v2_reg, v3_reg, v4_reg;
    logic      rdy1, rdy2, rdy3, rdy4;
    aat_load_t load;

    assign rdy4 = !v4_reg || out_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign in_ready = rdy1;

    assign load.s1 = rdy1 && in_valid;
    assign load.s2 = rdy2 && v1_reg;
    assign load.s3 = rdy3 && v2_reg;
    assign load.s4 = rdy4 && v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    logic clip_x, clip_y, clip_z;

    aat_axis u_axis_x (
        .clk    (clk),
        .load   (load),
        .lo_x   (lo_x),
        .lo_y   (lo_y),
        .lo_z   (lo_z),
        .hi_x   (hi_x),
        .hi_y   (hi_y),
        .hi_z   (hi_z),
        .row_a  (row0_a_reg),
        .row_b  (row0_b_reg),
        .out_lo (out_lo_x),
        .out_hi (out_hi_x),
        .clip   (clip_x)
    );

    aat_axis u_axis_y (
        .clk    (clk),
        .load   (load),
        .lo_x   (lo_x),
        .lo_y   (lo_y),
        .lo_z   (lo_z),
        .hi_x   (hi_x),
        .hi_y   (hi_y),
        .hi_z   (hi_z),
        .row_a  (row1_a_reg),
        .row_b  (row1_b_reg),
        .out_lo (out_lo_y),
        .out_hi (out_hi_y),
        .clip   (clip_y)
    );

    aat_axis u_axis_z (
        .clk    (clk),
        .load   (load),
        .lo_x   (lo_x),
        .lo_y   (lo_y),
        .lo_z   (lo_z),
        .hi_x   (hi_x),
        .hi_y   (hi_y),
        .hi_z   (hi_z),
        .row_a  (row2_a_reg),
        .row_b  (row2_b_reg),
        .out_lo (out_lo_z),
        .out_hi (out_hi_z),
        .clip   (clip_z)
    );

    assign out_valid = v4_reg;
    assign clipped   = clip_x || clip_y || clip_z;

endmodule

// File: rtl/core/aat_axis.sv
// One output axis of the box transform: products, per-term extremes, sums, saturation.
module aat_axis
    import aat_pkg::*;
(
    input  logic                       clk,
    input  aat_load_t                  load,
    input  logic signed [COORD_W-1:0]  lo_x,
    input  logic signed [COORD_W-1:0]  lo_y,
    input  logic signed [COORD_W-1:0]  lo_z,
    input  logic signed [COORD_W-1:0]  hi_x,
    input  logic signed [COORD_W-1:0]  hi_y,
    input  logic signed [COORD_W-1:0]  hi_z,
    input  logic [CFG_W-1:0]           row_a,
    input  logic [CFG_W-1:0]           row_b,
    output logic signed [COORD_W-1:0]  out_lo,
    output logic signed [COORD_W-1:0]  out_hi,
    output logic                       clip
);

    logic signed [COORD_W-1:0] m0, m1, m2, tr;

    logic signed [PROD_W-1:0] plo_reg  [3];
    logic signed [PROD_W-1:0] phi_reg  [3];
    logic signed [PROD_W-1:0] tmin_reg [3];
    logic signed [PROD_W-1:0] tmax_reg [3];
    logic signed [SUM_W-1:0]  smin_reg, smax_reg;
    logic signed [SUM_W-1:0]  smin_next, smax_next;
    logic signed [ACC_W-1:0]  vmin, vmax, tr_ext;
    logic signed [COORD_W-1:0] lo_reg, hi_reg;
    logic                      clip_reg;

    assign m0 = row_a[CFG_W-1:COORD_W];
    assign m1 = row_a[COORD_W-1:0];
    assign m2 = row_b[CFG_W-1:COORD_W];
    assign tr = row_b[COORD_W-1:0];

    // Stage 1: both candidate products of every matrix term.
    always_ff @(posedge clk)
    begin
        if (load.s1)
        begin
            plo_reg[0] <= PROD_W'(m0) * PROD_W'(lo_x);
            phi_reg[0] <= PROD_W'(m0) * PROD_W'(hi_x);
            plo_reg[1] <= PROD_W'(m1) * PROD_W'(lo_y);
            phi_reg[1] <= PROD_W'(m1) * PROD_W'(hi_y);
            plo_reg[2] <= PROD_W'(m2) * PROD_W'(lo_z);
            phi_reg[2] <= PROD_W'(m2) * PROD_W'(hi_z);
        end
    end

    // Stage 2: each term picks its smaller and larger candidate.
    always_ff @(posedge clk)
    begin
        if (load.s2)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (plo_reg[j] < phi_reg[j])
                begin
                    tmin_reg[j] <= plo_reg[j];
                    tmax_reg[j] <= phi_reg[j];
                end
                else
                begin
                    tmin_reg[j] <= phi_reg[j];
                    tmax_reg[j] <= plo_reg[j];
                end
            end
        end
    end

    // Stage 3: exact sums of the term extremes.
    assign smin_next = SUM_W'(tmin_reg[0]) + SUM_W'(tmin_reg[1]) + SUM_W'(tmin_reg[2]);
    assign smax_next = SUM_W'(tmax_reg[0]) + SUM_W'(tmax_reg[1]) + SUM_W'(tmax_reg[2]);

    always_ff @(posedge clk)
    begin
        if (load.s3)
        begin
            smin_reg <= smin_next;
            smax_reg <= smax_next;
        end
    end

    // Stage 4: floor to Q16.16, add the translation, clamp. The part-select
    // drops the sign, so it is restored before the extension.
    assign tr_ext = ACC_W'(tr);
    assign vmin = ACC_W'($signed(smin_reg[SUM_W-1:Q_FRAC])) + tr_ext;
    assign vmax = ACC_W'($signed(smax_reg[SUM_W-1:Q_FRAC])) + tr_ext;

    always_ff @(posedge clk)
    begin
        if (load.s4)
        begin
            if (vmin > SAT_MAX)
                lo_reg <= SAT_MAX[COORD_W-1:0];
            else if (vmin < SAT_MIN)
                lo_reg <= SAT_MIN[COORD_W-1:0];
            else
                lo_reg <= vmin[COORD_W-1:0];

            if (vmax > SAT_MAX)
                hi_reg <= SAT_MAX[COORD_W-1:0];
            else if (vmax < SAT_MIN)
                hi_reg <= SAT_MIN[COORD_W-1:0];
            else
                hi_reg <= vmax[COORD_W-1:0];

            clip_reg <= (vmax > SAT_MAX) || (vmin < SAT_MIN);
        end
    end

    assign out_lo = lo_reg;
    assign out_hi = hi_reg;
    assign clip   = clip_reg;

endmodule

// File: bench/aabb_affine_transform_test.sv
// Self-checking testbench for the axis-aligned box affine transform pipeline.
module aabb_affine_transform_test;
    timeunit 1ns;
    timeprecision 1ps;

    import aat_pkg::*;

    // The trailing wait before a register write and at the end of the run is
    // reckoned from the pipeline latency.
    localparam int PIPE_LATENCY    = 4;
    // The longest quiet stretch in a correct run is a sender gap, a receiver
    // stall and the pipeline latency, or a pause for register writes, and this
    // limit leaves a wide margin over it.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PRINT_LIMIT     = 40;
    localparam int RANDOM_PHASES   = 10;
    localparam int BOXES_PER_PHASE = 120;

    // Indexes that the port can carry but that name no register. Writes to
    // them must leave the matrix alone.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    // A few Q16.16 values that the directed part leans on.
    localparam logic signed [COORD_W-1:0] Q_ONE  = 32'sh0001_0000;
    localparam logic signed [COORD_W-1:0] Q_HALF = 32'sh0000_8000;
    localparam logic signed [COORD_W-1:0] Q_LSB  = 32'sh0000_0001;
    localparam logic signed [COORD_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] Q_MIN  = 32'sh8000_0000;

    // Saturation bounds at the width of the predictor's corner sums.
    localparam logic signed [67:0] WIDE_MAX = 68'sd2147483647;
    localparam logic signed [67:0] WIDE_MIN = -68'sd2147483648;

    typedef struct packed {
        logic signed [COORD_W-1:0] lo_x;
        logic signed [COORD_W-1:0] lo_y;
        logic signed [COORD_W-1:0] lo_z;
        logic signed [COORD_W-1:0] hi_x;
        logic signed [COORD_W-1:0] hi_y;
        logic signed [COORD_W-1:0] hi_z;
    } box_t;

    typedef struct packed {
        box_t box;
        logic clipped;
    } bound_t;

    // How the two sides of the pipeline throttle the traffic in one phase.
    typedef enum logic [1:0] {
        FLOW_STEADY,
        FLOW_GAPS,
        FLOW_STALLS,
        FLOW_BOTH
    } flow_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [COORD_W-1:0] lo_x;
    logic signed [COORD_W-1:0] lo_y;
    logic signed [COORD_W-1:0] lo_z;
    logic signed [COORD_W-1:0] hi_x;
    logic signed [COORD_W-1:0] hi_y;
    logic signed [COORD_W-1:0] hi_z;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [COORD_W-1:0] out_lo_x;
    logic signed [COORD_W-1:0] out_lo_y;
    logic signed [COORD_W-1:0] out_lo_z;
    logic signed [COORD_W-1:0] out_hi_x;
    logic signed [COORD_W-1:0] out_hi_y;
    logic signed [COORD_W-1:0] out_hi_z;
    logic                      clipped;

    // The predictor's own copy of the six matrix registers, kept in step with
    // every write that the testbench makes.
    logic [CFG_W-1:0] matrix_rows [6];

    // Bounds still owed by the pipeline, oldest first.
    bound_t expected_bounds [$];

    int    error_count = 0;
    int    bounds_seen = 0;
    flow_t flow        = FLOW_STEADY;
    int    burst_left  = 0;
    int    ready_run   = 0;
    int    ready_stall = 0;

    aabb_affine_transform DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Predicted transform of one box. Every corner is taken through the three
    // matrix rows with exact products, the sum is floored to Q16.16, the
    // translation is added, and the coordinate is clamped to the Q16.16 range.
    // The box result is the per-axis extreme over all eight corners, so a box
    // whose minimum lies above its maximum still yields an ordered result.
    function automatic bound_t transform_box(box_t b);
        logic signed [COORD_W-1:0] m [3][4];
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic signed [65:0]        dot;
        logic signed [67:0]        coord;
        logic signed [COORD_W-1:0] c;
        logic signed [COORD_W-1:0] lo_c [3];
        logic signed [COORD_W-1:0] hi_c [3];
        bound_t                    r;

        r.clipped = 1'b0;
        for (int row = 0; row < 3; row++)
        begin
            m[row][0] = matrix_rows[2 * row][63:32];
            m[row][1] = matrix_rows[2 * row][31:0];
            m[row][2] = matrix_rows[2 * row + 1][63:32];
            m[row][3] = matrix_rows[2 * row + 1][31:0];
        end
        for (int k = 0; k < 8; k++)
        begin
            cx = ((k & 4) != 0) ? b.hi_x : b.lo_x;
            cy = ((k & 2) != 0) ? b.hi_y : b.lo_y;
            cz = ((k & 1) != 0) ? b.hi_z : b.lo_z;
            for (int row = 0; row < 3; row++)
            begin
                // The wide left-hand side makes every product exact.
                dot   = m[row][0] * cx + m[row][1] * cy + m[row][2] * cz;
                coord = (dot >>> Q_FRAC) + m[row][3];
                if (coord > WIDE_MAX)
                begin
                    c         = Q_MAX;
                    r.clipped = 1'b1;
                end
                else if (coord < WIDE_MIN)
                begin
                    c         = Q_MIN;
                    r.clipped = 1'b1;
                end
                else
                    c = coord[COORD_W-1:0];
                if (k == 0 || c < lo_c[row])
                    lo_c[row] = c;
                if (k == 0 || c > hi_c[row])
                    hi_c[row] = c;
            end
        end
        r.box.lo_x = lo_c[0];
        r.box.lo_y = lo_c[1];
        r.box.lo_z = lo_c[2];
        r.box.hi_x = hi_c[0];
        r.box.hi_y = hi_c[1];
        r.box.hi_z = hi_c[2];
        return r;
    endfunction

    // Random coordinate: now and then an extreme, otherwise a random word
    // scaled down by a random amount so that small and large boxes both occur.
    function automatic logic signed [COORD_W-1:0] random_coord();
        case ($urandom_range(0, 15))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return -Q_LSB;
            default: return $signed($urandom) >>> $urandom_range(0, 20);
        endcase
    endfunction

    // Random matrix entry, biased toward modest scales so that most corners
    // stay in range and the min/max selection does the real work.
    function automatic logic signed [COORD_W-1:0] random_entry();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return Q_ONE;
            2:       return -Q_ONE;
            3:       return Q_HALF;
            4:       return Q_MAX;
            5:       return Q_MIN;
            6:       return $signed($urandom);
            default: return $signed($urandom) >>> $urandom_range(8, 24);
        endcase
    endfunction

    // Random box: mostly a well-formed box with a random extent above its
    // minimum corner, the rest two unrelated corners, often inverted.
    function automatic box_t random_box();
        box_t b;

        b.lo_x = random_coord();
        b.lo_y = random_coord();
        b.lo_z = random_coord();
        if ($urandom_range(0, 4) == 0)
        begin
            b.hi_x = random_coord();
            b.hi_y = random_coord();
            b.hi_z = random_coord();
        end
        else
        begin
            b.hi_x = b.lo_x + ($urandom >> $urandom_range(4, 31));
            b.hi_y = b.lo_y + ($urandom >> $urandom_range(4, 31));
            b.hi_z = b.lo_z + ($urandom >> $urandom_range(4, 31));
        end
        return b;
    endfunction

    // One line per mismatch, up to a limit, and a count of all of them.
    task automatic report_mismatch(input string what, input logic [COORD_W-1:0] got,
                                   input logic [COORD_W-1:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("[%0t] bound %0d, %s: got %h, expected %h",
                     $time, bounds_seen, what, got, want);
    endtask

    // Presents one box and returns at the edge where its transaction is
    // accepted. Valid is left high so that a following box can go out on the
    // next cycle; a gap, when one is due, lowers it first. In phases with sender
    // gaps the sender runs in bursts of random length separated by random gaps.
    task automatic send_box(input box_t b);
        int gap;

        gap = 0;
        if (flow == FLOW_GAPS || flow == FLOW_BOTH)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 10);
                burst_left = $urandom_range(1, 30);
            end
            burst_left--;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        lo_x     <= b.lo_x;
        lo_y     <= b.lo_y;
        lo_z     <= b.lo_z;
        hi_x     <= b.hi_x;
        hi_y     <= b.hi_y;
        hi_z     <= b.hi_z;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_bounds.push_back(transform_box(b));
    endtask

    // Stops the sender and waits until every owed bound has come back, then
    // lets the pipeline run empty before anything touches the registers.
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (expected_bounds.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    // One register write, mirrored into the predictor. Indexes past the last
    // register are ignored by the block and so by the predictor as well.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (index <= CFG_ROW2_B)
            matrix_rows[index] = value;
    endtask

    // The identity matrix left by reset: boxes at the extremes of the range,
    // the full range, an inverted box and fractional coordinates.
    task automatic test_reset_identity();
        flow = FLOW_STEADY;
        send_box({6{32'sh0}});
        send_box({6{Q_MAX}});
        send_box({6{Q_MIN}});
        send_box({Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX});
        send_box({Q_MAX, 32'sh1234_5678, -Q_LSB, Q_MIN, Q_ONE, Q_LSB});
        send_box({-Q_ONE - Q_HALF, Q_HALF >>> 1, -Q_LSB, 32'sh0002_C000, 32'sh0064_0000, 32'sh0});
    endtask

    // Matrices whose rows overflow in both directions. A zero box lands right
    // on the clamp values without clipping, while any extent pushes past them.
    task automatic test_saturation();
        wait_for_idle();
        flow = FLOW_BOTH;
        write_register(CFG_ROW0_A, {Q_MAX, Q_MAX});
        write_register(CFG_ROW0_B, {Q_MAX, Q_MAX});
        write_register(CFG_ROW1_A, {Q_MIN, Q_MIN});
        write_register(CFG_ROW1_B, {Q_MIN, Q_MIN});
        write_register(CFG_ROW2_A, {Q_ONE, -Q_ONE});
        write_register(CFG_ROW2_B, {Q_HALF, Q_MIN});
        send_box({6{32'sh0}});
        send_box({32'sh0, 32'sh0, 32'sh0, Q_ONE, Q_ONE, Q_ONE});
        send_box({Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX});
        send_box({Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN});
        send_box({-Q_LSB, -Q_LSB, -Q_LSB, Q_LSB, Q_LSB, Q_LSB});
    endtask

    // Half and single-step entries against odd coordinates, so that the sum
    // carries a fraction below the last bit and must round toward minus
    // infinity, on either sign.
    task automatic test_floor_rounding();
        wait_for_idle();
        flow = FLOW_STALLS;
        write_register(CFG_ROW0_A, {Q_HALF, -Q_HALF});
        write_register(CFG_ROW0_B, {Q_LSB, 32'sh0});
        write_register(CFG_ROW1_A, {-Q_LSB, Q_HALF});
        write_register(CFG_ROW1_B, {Q_HALF, -Q_ONE});
        write_register(CFG_ROW2_A, {32'sh0000_4000, 32'shFFFF_C000});
        write_register(CFG_ROW2_B, {32'sh0000_C000, Q_LSB});
        send_box({-Q_LSB, -Q_LSB, -Q_LSB, Q_LSB, Q_LSB, Q_LSB});
        send_box({-32'sd3, 32'sd5, -32'sd7, 32'sd3, -32'sd5, 32'sd7});
        send_box({-Q_ONE - Q_LSB, Q_LSB, -Q_HALF - Q_LSB, Q_LSB, Q_ONE + Q_LSB, Q_HALF});
    endtask

    // Writes to the indexes past the last register: the matrix from the
    // previous test must stay in force.
    task automatic test_spare_indexes();
        wait_for_idle();
        flow = FLOW_STEADY;
        write_register(CFG_SPARE_6, {$urandom, $urandom});
        write_register(CFG_SPARE_7, '1);
        send_box({-Q_LSB, -Q_LSB, -Q_LSB, Q_LSB, Q_LSB, Q_LSB});
        send_box({Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX});
    endtask

    // Random boxes in phases. The first phases load register extremes (all
    // zero, all ones, the largest and the most negative entries), the rest
    // random matrices. The flow pattern changes from phase to phase so gaps
    // and stalls fall on every stage, and some phases run without either.
    task automatic test_random_boxes();
        logic [CFG_W-1:0] value;

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_for_idle();
            flow = flow_t'(phase % 4);
            for (int i = CFG_ROW0_A; i <= CFG_ROW2_B; i++)
            begin
                case (phase)
                    0:       value = '0;
                    1:       value = '1;
                    2:       value = {Q_MAX, Q_MAX};
                    3:       value = {Q_MIN, Q_MIN};
                    default: value = {random_entry(), random_entry()};
                endcase
                write_register(CFG_IDX_W'(i), value);
            end
            if ($urandom_range(0, 2) == 0)
                write_register(($urandom_range(0, 1) == 0) ? CFG_SPARE_6 : CFG_SPARE_7,
                               {$urandom, $urandom});
            for (int n = 0; n < BOXES_PER_PHASE; n++)
                send_box(random_box());
        end
    endtask

    // The receiver stalls on a pattern of its own: runs of ready of random
    // length, each followed by a stall that is usually short and now and then
    // long. Phases without receiver throttling keep ready high.
    always @(posedge clk)
    begin
        if (flow == FLOW_STEADY || flow == FLOW_GAPS)
            out_ready <= 1'b1;
        else if (ready_stall > 0)
        begin
            out_ready <= 1'b0;
            ready_stall--;
        end
        else if (ready_run > 0)
        begin
            out_ready <= 1'b1;
            ready_run--;
        end
        else
        begin
            out_ready   <= 1'b1;
            ready_run   = $urandom_range(0, 15);
            ready_stall = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24)
                                                     : $urandom_range(1, 4);
        end
    end

    // Every transaction on the result side is matched against the oldest
    // owed bound, field by field. Values are read in the active region of the
    // edge, so they are the ones that the handshake actually moved.
    always @(posedge clk)
    begin : check_bounds
        bound_t want;

        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bounds.size() == 0)
                report_mismatch("transaction with no box outstanding", out_lo_x, '0);
            else
            begin
                want = expected_bounds.pop_front();
                if (out_lo_x !== want.box.lo_x)
                    report_mismatch("out_lo_x", out_lo_x, want.box.lo_x);
                if (out_lo_y !== want.box.lo_y)
                    report_mismatch("out_lo_y", out_lo_y, want.box.lo_y);
                if (out_lo_z !== want.box.lo_z)
                    report_mismatch("out_lo_z", out_lo_z, want.box.lo_z);
                if (out_hi_x !== want.box.hi_x)
                    report_mismatch("out_hi_x", out_hi_x, want.box.hi_x);
                if (out_hi_y !== want.box.hi_y)
                    report_mismatch("out_hi_y", out_hi_y, want.box.hi_y);
                if (out_hi_z !== want.box.hi_z)
                    report_mismatch("out_hi_z", out_hi_z, want.box.hi_z);
                if (clipped !== want.clipped)
                    report_mismatch("clipped", 32'(clipped), 32'(want.clipped));
            end
            bounds_seen++;
        end
    end

    // Ends the run if no transaction moves on either channel for too long,
    // which covers a hung handshake and a result that never arrives.
    initial
    begin : watchdog
        int quiet;

        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        // Every input of the block holds a known value from time zero.
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_ROW0_A;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        lo_x      <= '0;
        lo_y      <= '0;
        lo_z      <= '0;
        hi_x      <= '0;
        hi_y      <= '0;
        hi_z      <= '0;
        out_ready <= 1'b1;

        matrix_rows[CFG_ROW0_A] = ROW0_A_RESET;
        matrix_rows[CFG_ROW0_B] = ROW0_B_RESET;
        matrix_rows[CFG_ROW1_A] = ROW1_A_RESET;
        matrix_rows[CFG_ROW1_B] = ROW1_B_RESET;
        matrix_rows[CFG_ROW2_A] = ROW2_A_RESET;
        matrix_rows[CFG_ROW2_B] = ROW2_B_RESET;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_identity();
        test_saturation();
        test_floor_rounding();
        test_spare_indexes();
        test_random_boxes();

        // Drain the pipeline and give a stray extra result the chance to show.
        wait_for_idle();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
